### hdl/deq_pkg.sv
// Shared types and constants for the double-ended queue with search.
// Used by deq_cell and double_ended_queue_with_search_unit; no dependencies.
package deq_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_SEARCH     = 3'd4,
		OP_DUMP       = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		KIND_FOUND      = 3'd0,
		KIND_NOT_FOUND  = 3'd1,
		KIND_EMPTY      = 3'd2,
		KIND_ELEMENT    = 3'd3,
		KIND_DUMP_EMPTY = 3'd4,
		KIND_FULL       = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DUMP
	} state_t;

	// what every cell does this cycle
	typedef enum logic [2:0] {
		CM_HOLD,
		CM_FROM_LEFT,
		CM_FROM_RIGHT,
		CM_ROTATE,
		CM_APPEND
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		logic       at_tail;
	} cell_ctl_t;

endpackage

### hdl/deq_cell.sv
// One storage cell of the queue chain: holds one element, shifts to either neighbor,
// takes the head element on rotation, or loads a new tail value. Depends on deq_pkg.
module deq_cell
	import deq_pkg::*;
(
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	input  logic [DATA_W-1:0] head,
	input  logic [DATA_W-1:0] value,
	output logic [DATA_W-1:0] data
);

	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.mode)
			CM_FROM_LEFT:  data_d = left;
			CM_FROM_RIGHT: data_d = right;
			// tail cell closes the ring of occupied cells
			CM_ROTATE:     data_d = ctl.at_tail ? head : right;
			CM_APPEND: begin
				if (ctl.at_tail) begin
					data_d = value;
				end
			end
			default:       data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

### hdl/double_ended_queue_with_search_unit.sv
// Top level of the double-ended queue: cell chain plus operation sequencer and output register.
// Depends on deq_pkg and deq_cell.
//
// Elements sit in a chain of DEPTH cells; the front element is in cell 0 whenever no search
// or dump is running. A push front or pop front shifts the whole chain by one cell, a push
// back loads the new value into the cell at the tail, and a pop back only lowers the occupancy.
// Search and dump rotate the occupied cells once around the ring, one cell per cycle, looking
// at cell 0 each time, so after one is accepted it holds the input until every stored element
// has passed cell 0 (a dump advances only while its result can be handed on). A search loads
// its one result at the end of its final rotation cycle; the contents are back in order when
// it ends. A new transaction is taken only when no search or dump is running and the output
// register is free or being emptied in that cycle. Pushes to a full queue give a full result;
// pops on an empty queue and unknown operations are dropped silently.
module double_ended_queue_with_search_unit
	import deq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [2:0]               op,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [2:0]               kind,
	output logic signed [DATA_W-1:0] element,
	output logic                     last
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  occ_q, occ_d;
	logic [IDX_W-1:0]  cnt_q, cnt_d;
	logic [DATA_W-1:0] key_q, key_d;
	logic              match_q, match_d;

	logic              out_valid_q, out_valid_d;
	kind_t             kind_q, kind_d;
	logic [DATA_W-1:0] element_q, element_d;
	logic              last_q, last_d;

	cell_mode_t        mode;
	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [IDX_W-1:0]  tail_pos;
	logic [CNT_W-1:0]  occ_m1;
	logic              acc;
	logic              out_free;
	logic              full;
	logic              empty;
	logic              final_step;
	logic              hit;

	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != ST_IDLE) || !out_free;
	assign acc        = in_valid && !in_stall;
	assign full       = (occ_q == CNT_W'(DEPTH));
	assign empty      = (occ_q == '0);
	assign occ_m1     = occ_q - CNT_W'(1);
	assign final_step = ({1'b0, cnt_q} == occ_m1);
	assign hit        = (cell_data[0] == key_q);
	// append writes slot occ, rotation wraps cell 0 into slot occ-1
	assign tail_pos   = (state_q == ST_IDLE) ? occ_q[IDX_W-1:0] : occ_m1[IDX_W-1:0];

	always_comb begin
		state_d     = state_q;
		occ_d       = occ_q;
		cnt_d       = cnt_q;
		key_d       = key_q;
		match_d     = match_q;
		mode        = CM_HOLD;
		out_valid_d = out_valid_q && out_stall;
		kind_d      = kind_q;
		element_d   = element_q;
		last_d      = last_q;

		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (op_t'(op))
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							if (full) begin
								out_valid_d = 1'b1;
								kind_d      = KIND_FULL;
								element_d   = '0;
								last_d      = 1'b1;
							end else begin
								mode  = (op_t'(op) == OP_PUSH_FRONT) ? CM_FROM_LEFT : CM_APPEND;
								occ_d = occ_q + CNT_W'(1);
							end
						end
						OP_POP_FRONT: begin
							if (!empty) begin
								mode  = CM_FROM_RIGHT;
								occ_d = occ_m1;
							end
						end
						OP_POP_BACK: begin
							if (!empty) begin
								occ_d = occ_m1;
							end
						end
						OP_SEARCH: begin
							if (empty) begin
								out_valid_d = 1'b1;
								kind_d      = KIND_EMPTY;
								element_d   = '0;
								last_d      = 1'b1;
							end else begin
								key_d   = value;
								cnt_d   = '0;
								match_d = 1'b0;
								state_d = ST_SEARCH;
							end
						end
						OP_DUMP: begin
							if (empty) begin
								out_valid_d = 1'b1;
								kind_d      = KIND_DUMP_EMPTY;
								element_d   = '0;
								last_d      = 1'b1;
							end else begin
								cnt_d   = '0;
								state_d = ST_DUMP;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SEARCH: begin
				// output register is free here: nothing loads it during a search
				mode    = CM_ROTATE;
				cnt_d   = cnt_q + IDX_W'(1);
				match_d = match_q || hit;
				if (final_step) begin
					out_valid_d = 1'b1;
					kind_d      = (match_q || hit) ? KIND_FOUND : KIND_NOT_FOUND;
					element_d   = '0;
					last_d      = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_DUMP: begin
				if (out_free) begin
					mode        = CM_ROTATE;
					cnt_d       = cnt_q + IDX_W'(1);
					out_valid_d = 1'b1;
					kind_d      = KIND_ELEMENT;
					element_d   = cell_data[0];
					last_d      = final_step;
					if (final_step) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			cnt_q       <= '0;
			match_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			occ_q       <= occ_d;
			cnt_q       <= cnt_d;
			match_q     <= match_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q     <= key_d;
		kind_q    <= kind_d;
		element_q <= element_d;
		last_q    <= last_d;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctl_t         ctl;
		logic [DATA_W-1:0] left_data;
		logic [DATA_W-1:0] right_data;

		assign ctl.mode    = mode;
		assign ctl.at_tail = (tail_pos == IDX_W'(i));

		if (i == 0) begin : g_first
			assign left_data = value;
		end else begin : g_inner_l
			assign left_data = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_end
			assign right_data = cell_data[i];
		end else begin : g_inner_r
			assign right_data = cell_data[i+1];
		end

		deq_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.left  (left_data),
			.right (right_data),
			.head  (cell_data[0]),
			.value (value),
			.data  (cell_data[i])
		);
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign element   = element_q;
	assign last      = last_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(DEPTH))
		else $error("occupancy above depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ({1'b0, cnt_q} < occ_q))
		else $error("scan position past last element");

	a_occ_steady_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> (occ_q == $past(occ_q)))
		else $error("occupancy changed during search or dump");

endmodule

### test/tb.sv
// Self-checking testbench for double_ended_queue_with_search_unit.
// Needs deq_pkg and the RTL only. A mirror of the deque predicts each result, and
// random bursts, gaps and output stalls exercise the valid/stall handshakes.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import deq_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_ITEMS = 210;
	localparam logic [2:0] OP_UNUSED_6 = 3'd6;
	localparam logic [2:0] OP_UNUSED_7 = 3'd7;

	// Mirror of the deque contents plus the results still owed by the block.
	class deque_tracker;
		typedef struct {
			kind_t                    kind;
			logic signed [DATA_W-1:0] element;
			logic                     last;
		} result_t;

		logic signed [DATA_W-1:0] mirror[$];
		result_t                  owed[$];
		int                       errors;

		function new();
			errors = 0;
		endfunction

		function void owe(kind_t k, logic signed [DATA_W-1:0] e, logic l);
			result_t r;
			r.kind = k;
			r.element = e;
			r.last = l;
			owed.push_back(r);
		endfunction

		// Called once per accepted input transaction.
		function void apply_op(logic [2:0] op_code, logic signed [DATA_W-1:0] v);
			bit hit;
			hit = 0;
			case (op_code)
				OP_PUSH_FRONT: begin
					if (mirror.size() >= DEPTH)
						owe(KIND_FULL, '0, 1'b1);
					else
						mirror.push_front(v);
				end
				OP_PUSH_BACK: begin
					if (mirror.size() >= DEPTH)
						owe(KIND_FULL, '0, 1'b1);
					else
						mirror.push_back(v);
				end
				OP_POP_FRONT: begin
					if (mirror.size() != 0)
						void'(mirror.pop_front());
				end
				OP_POP_BACK: begin
					if (mirror.size() != 0)
						void'(mirror.pop_back());
				end
				OP_SEARCH: begin
					if (mirror.size() == 0) begin
						owe(KIND_EMPTY, '0, 1'b1);
					end else begin
						foreach (mirror[i])
							if (mirror[i] === v)
								hit = 1;
						owe(hit ? KIND_FOUND : KIND_NOT_FOUND, '0, 1'b1);
					end
				end
				OP_DUMP: begin
					if (mirror.size() == 0)
						owe(KIND_DUMP_EMPTY, '0, 1'b1);
					else
						foreach (mirror[i])
							owe(KIND_ELEMENT, mirror[i], i == mirror.size() - 1);
				end
				default: ;
			endcase
		endfunction

		task flag_mismatch(string msg);
			errors++;
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		endtask

		task check_output(logic [2:0] k, logic signed [DATA_W-1:0] e, logic l);
			result_t want;
			if (owed.size() == 0) begin
				flag_mismatch($sformatf("unexpected result kind=%0d element=%0d last=%0b",
					k, e, l));
				return;
			end
			want = owed.pop_front();
			if (want.kind !== k)
				flag_mismatch($sformatf("kind %0d, expected %0d", k, want.kind));
			if (want.element !== e)
				flag_mismatch($sformatf("element %0d, expected %0d", e, want.element));
			if (want.last !== l)
				flag_mismatch($sformatf("last %0b, expected %0b", l, want.last));
		endtask

		function int owed_count();
			return owed.size();
		endfunction

		function int depth_used();
			return mirror.size();
		endfunction

		function logic signed [DATA_W-1:0] stored_value();
			if (mirror.size() == 0)
				return '0;
			return mirror[$urandom_range(mirror.size() - 1, 0)];
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [2:0]               op = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [2:0]               kind;
	logic signed [DATA_W-1:0] element;
	logic                     last;

	deque_tracker tracker = new();
	int           burst_left = 0;
	int           counted_items = 0;
	int           cycle_count = 0;

	double_ended_queue_with_search_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind     (kind),
		.element  (element),
		.last     (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task send_item(logic [2:0] o, logic signed [DATA_W-1:0] v);
		in_valid <= 1'b1;
		op <= o;
		value <= v;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		tracker.apply_op(o, v);
		if (o <= OP_DUMP)
			counted_items++;
		@(negedge clk);
	endtask

	task issue(logic [2:0] o, logic signed [DATA_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(7, 0) == 0) ? 30 : $urandom_range(12, 1);
		end
		burst_left--;
		send_item(o, v);
	endtask

	function logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(3, 0))
			0: begin
				case ($urandom_range(4, 0))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 32'sh0000_0000;
					3: return -32'sd1;
					default: return 32'sd1;
				endcase
			end
			1: return $urandom_range(7, 0);  // small range gives duplicates and search hits
			default: return $urandom;
		endcase
	endfunction

	task random_op();
		int unsigned r;
		r = $urandom_range(99, 0);
		if (r < 22)
			issue(OP_PUSH_FRONT, pick_value());
		else if (r < 44)
			issue(OP_PUSH_BACK, pick_value());
		else if (r < 56)
			issue(OP_POP_FRONT, pick_value());
		else if (r < 68)
			issue(OP_POP_BACK, pick_value());
		else if (r < 76)
			issue(OP_SEARCH, tracker.stored_value());
		else if (r < 82)
			issue(OP_SEARCH, pick_value());
		else if (r < 94)
			issue(OP_DUMP, pick_value());
		else
			issue(r[0] ? OP_UNUSED_7 : OP_UNUSED_6, pick_value());
	endtask

	// Fill to capacity, poke at the full queue, then drain part of it.
	task fill_and_drain();
		int drain;
		while (tracker.depth_used() < DEPTH)
			issue($urandom_range(1, 0) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
		issue(OP_PUSH_FRONT, pick_value());
		issue(OP_PUSH_BACK, pick_value());
		issue(OP_SEARCH, tracker.stored_value());
		issue(OP_SEARCH, $urandom);
		issue(OP_DUMP, '0);
		drain = $urandom_range(40, 10);
		repeat (drain)
			issue($urandom_range(1, 0) ? OP_POP_BACK : OP_POP_FRONT, $urandom);
	endtask

	// Receiver stall pattern: segments of free flow, random, periodic or long runs.
	int stall_mode = 0;
	int seg_left = 0;
	int run_left = 0;
	always @(negedge clk) begin
		if (seg_left == 0) begin
			stall_mode = $urandom_range(3, 0);
			seg_left = $urandom_range(60, 10);
		end
		seg_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= $urandom_range(1, 0);
			2: out_stall <= (seg_left % 3 == 0);
			default: begin
				if (run_left == 0) begin
					run_left = $urandom_range(8, 1);
					out_stall <= ~out_stall;
				end
				run_left--;
			end
		endcase
	end

	always @(posedge clk)
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			tracker.check_output(kind, element, last);

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty cases, unknown ops, extremes, hits and misses
		issue(OP_DUMP, '0);
		issue(OP_SEARCH, 32'sh0000_0000);
		issue(OP_POP_FRONT, '0);
		issue(OP_POP_BACK, '0);
		issue(OP_UNUSED_6, 32'sh7fff_ffff);
		issue(OP_UNUSED_7, 32'sh8000_0000);
		issue(OP_PUSH_BACK, 32'sh7fff_ffff);
		issue(OP_PUSH_FRONT, 32'sh8000_0000);
		issue(OP_PUSH_BACK, 32'sh0000_0000);
		issue(OP_PUSH_FRONT, -32'sd1);
		issue(OP_SEARCH, 32'sh8000_0000);
		issue(OP_SEARCH, 32'sh7fff_fffe);  // one bit away from a stored value
		issue(OP_SEARCH, 32'sh0000_0000);
		issue(OP_DUMP, '0);
		issue(OP_POP_FRONT, '0);
		issue(OP_POP_BACK, '0);
		issue(OP_DUMP, '0);
		issue(OP_SEARCH, -32'sd1);
		issue(OP_PUSH_FRONT, 32'sh5555_5555);
		issue(OP_PUSH_BACK, 32'shaaaa_aaaa);
		issue(OP_DUMP, '0);
		repeat (4) issue(OP_POP_BACK, '0);
		issue(OP_POP_FRONT, '0);
		issue(OP_DUMP, '0);

		while (counted_items < RANDOM_ITEMS) begin
			if (counted_items == 60)
				fill_and_drain();
			else
				random_op();
		end

		in_valid <= 1'b0;
		while (tracker.owed_count() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

### files.f
hdl/deq_pkg.sv
hdl/deq_cell.sv
hdl/double_ended_queue_with_search_unit.sv
test/tb.sv
